// ===== src/lpts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpts_pkg: shared types for the LRU page tag store
// Request and response payloads, operation codes and the slot update command.
// ----------------------------------------------------------------------------
package lpts_pkg;

  localparam int PAGE_W = 32;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 5;
  localparam int OCC_W  = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SAVE  = 2'd1,
    KIND_EVICT = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page_id;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              fetch_needed;
    logic              write_back;
    logic              victim_valid;
    logic [PAGE_W-1:0] victim_id;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  // What the slot array does with the request that advances.
  typedef struct packed {
    logic touch;      // load/save hit: make hit slot most recent
    logic drop;       // evict hit: remove hit slot
    logic insert;     // load/save miss: fill free slot as most recent
    logic evict_lru;  // insertion pushes out the least recent slot
  } upd_t;

endpackage

// ===== src/lru_page_tag_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_tag_store: fully associative page tag store, LRU replacement
// Request channel (req_valid/req_ready/req) carries an operation and a page
// id; the response channel (rsp_valid/rsp_ready/rsp) returns one transfer per
// request, in order. cfg_wen/cfg_wdata write the capacity register.
//
// A request transferred into the request register moves on to the response
// register when that register is free or draining. Throughput is one request
// per cycle while the receiver does not stall, set by the combinational tag
// compare and age update that sit between the request and response registers.
//
// Reset clears all valid bits, ages and occupancy and sets capacity to 16;
// no clearing sweep is needed. When the receiver stalls, the response
// register holds its transfer and the request register holds one more
// request; req_ready drops only when both are occupied.
// Write capacity only while no request is in flight.
// ----------------------------------------------------------------------------
module lru_page_tag_store #(
  parameter int ENTRIES  = 16,
  parameter int ID_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  lpts_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output lpts_pkg::rsp_t             rsp,
  input  logic                       cfg_wen,
  input  logic [lpts_pkg::CFG_W-1:0] cfg_wdata
);
  import lpts_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [CFG_W-1:0]    capacity;
  req_t                pend;
  logic                pend_valid;
  logic                advance;

  logic                slot_valid [ENTRIES];
  logic [ID_WIDTH-1:0] slot_page  [ENTRIES];
  logic [AW-1:0]       slot_age   [ENTRIES];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [ENTRIES-1:0]  hit_sel;
  logic [ENTRIES-1:0]  victim_sel;
  logic [ENTRIES-1:0]  free_sel;
  logic [AW-1:0]       hit_age;
  upd_t                upd;
  rsp_t                rsp_next;

  // Advance the held request when the response register is free or draining.
  assign advance   = pend_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !pend_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req_ready) begin
      pend_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      pend <= req;
    end
  end

  lpts_lookup #(
    .ENTRIES  (ENTRIES),
    .ID_WIDTH (ID_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_lookup (
    .req        (pend),
    .capacity   (capacity),
    .slot_valid (slot_valid),
    .slot_page  (slot_page),
    .slot_age   (slot_age),
    .count      (count),
    .hit_sel    (hit_sel),
    .victim_sel (victim_sel),
    .free_sel   (free_sel),
    .hit_age    (hit_age),
    .count_next (count_next),
    .upd        (upd),
    .rsp        (rsp_next)
  );

  // State changes only when the request moves on to the response register.
  lpts_slots #(
    .ENTRIES  (ENTRIES),
    .ID_WIDTH (ID_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .upd        (upd),
    .id         (pend.page_id[ID_WIDTH-1:0]),
    .hit_sel    (hit_sel),
    .victim_sel (victim_sel),
    .free_sel   (free_sel),
    .hit_age    (hit_age),
    .count_next (count_next),
    .slot_valid (slot_valid),
    .slot_page  (slot_page),
    .slot_age   (slot_age),
    .count      (count)
  );

  // Response register: hold while stalled, refill on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/lpts_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpts_lookup: parallel tag compare and replacement decision
// Compares the request against every slot, picks victim and free slot and
// forms the response and the update command.
// ----------------------------------------------------------------------------
module lpts_lookup #(
  parameter int ENTRIES  = 16,
  parameter int ID_WIDTH = 32,
  parameter int AW       = $clog2(ENTRIES),
  parameter int CW       = $clog2(ENTRIES + 1)
) (
  input  lpts_pkg::req_t               req,
  input  logic [lpts_pkg::CFG_W-1:0]   capacity,
  input  logic                         slot_valid [ENTRIES],
  input  logic [ID_WIDTH-1:0]          slot_page  [ENTRIES],
  input  logic [AW-1:0]                slot_age   [ENTRIES],
  input  logic [CW-1:0]                count,
  output logic [ENTRIES-1:0]           hit_sel,
  output logic [ENTRIES-1:0]           victim_sel,
  output logic [ENTRIES-1:0]           free_sel,
  output logic [AW-1:0]                hit_age,
  output logic [CW-1:0]                count_next,
  output lpts_pkg::upd_t               upd,
  output lpts_pkg::rsp_t               rsp
);
  import lpts_pkg::*;

  localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [ID_WIDTH-1:0] id;
  logic [ID_WIDTH-1:0] victim_page;
  logic [CMPW-1:0]     cap_eff;
  logic [CMPW-1:0]     cap_ext;
  logic [CW-1:0]       count_m1;
  logic [ENTRIES-1:0]  lru_vec;
  logic [ENTRIES-1:0]  empty_vec;
  logic [ENTRIES-1:0]  free_cand;
  logic                hit;
  logic                is_fill;
  logic                full;

  assign id       = req.page_id[ID_WIDTH-1:0];
  assign count_m1 = count - CW'(1);
  assign cap_ext  = CMPW'(capacity);

  // Clamp capacity into 1..ENTRIES.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Valid ages are distinct 0..count-1, so the least recent has age count-1.
  always_comb begin
    hit_age     = '0;
    victim_page = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_sel[i]   = slot_valid[i] && (slot_page[i] == id);
      lru_vec[i]   = slot_valid[i] && (slot_age[i] == AW'(count_m1));
      empty_vec[i] = !slot_valid[i];
      if (hit_sel[i]) begin
        hit_age = hit_age | slot_age[i];
      end
      if (lru_vec[i]) begin
        victim_page = victim_page | slot_page[i];
      end
    end
  end

  assign hit     = |hit_sel;
  assign is_fill = ((req.kind == KIND_LOAD) || (req.kind == KIND_SAVE)) && !hit;
  assign full    = CMPW'(count) >= cap_eff;

  assign upd.touch     = ((req.kind == KIND_LOAD) || (req.kind == KIND_SAVE)) && hit;
  assign upd.drop      = (req.kind == KIND_EVICT) && hit;
  assign upd.insert    = is_fill;
  assign upd.evict_lru = is_fill && full;

  assign victim_sel = upd.evict_lru ? lru_vec : '0;

  // Lowest free slot, counting the victim as free.
  assign free_cand = victim_sel | empty_vec;
  assign free_sel  = free_cand & (~free_cand + ENTRIES'(1));

  always_comb begin
    count_next = count;
    if (upd.insert && !upd.evict_lru) begin
      count_next = count + CW'(1);
    end else if (upd.drop) begin
      count_next = count_m1;
    end
  end

  assign rsp.hit          = hit;
  assign rsp.fetch_needed = (req.kind == KIND_LOAD) && !hit;
  assign rsp.write_back   = (req.kind == KIND_SAVE);
  assign rsp.victim_valid = upd.evict_lru;
  assign rsp.victim_id    = upd.evict_lru ? PAGE_W'(victim_page) : '0;
  assign rsp.occupancy    = OCC_W'(count_next);

endmodule

// ===== src/lpts_slots.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpts_slots: slot tags, valid bits, recency ages and occupancy
// Applies one update command per advancing request.
// ----------------------------------------------------------------------------
module lpts_slots #(
  parameter int ENTRIES  = 16,
  parameter int ID_WIDTH = 32,
  parameter int AW       = $clog2(ENTRIES),
  parameter int CW       = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  lpts_pkg::upd_t      upd,
  input  logic [ID_WIDTH-1:0] id,
  input  logic [ENTRIES-1:0]  hit_sel,
  input  logic [ENTRIES-1:0]  victim_sel,
  input  logic [ENTRIES-1:0]  free_sel,
  input  logic [AW-1:0]       hit_age,
  input  logic [CW-1:0]       count_next,
  output logic                slot_valid [ENTRIES],
  output logic [ID_WIDTH-1:0] slot_page  [ENTRIES],
  output logic [AW-1:0]       slot_age   [ENTRIES],
  output logic [CW-1:0]       count
);
  import lpts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
        slot_age[i]   <= '0;
      end
    end else if (en) begin
      count <= count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        if (upd.touch) begin
          if (hit_sel[i]) begin
            slot_age[i] <= '0;
          end else if (slot_valid[i] && (slot_age[i] < hit_age)) begin
            slot_age[i] <= slot_age[i] + AW'(1);
          end
        end else if (upd.drop) begin
          if (hit_sel[i]) begin
            slot_valid[i] <= 1'b0;
          end else if (slot_valid[i] && (slot_age[i] > hit_age)) begin
            slot_age[i] <= slot_age[i] - AW'(1);
          end
        end else if (upd.insert) begin
          if (free_sel[i]) begin
            slot_valid[i] <= 1'b1;
            slot_age[i]   <= '0;
          end else if (victim_sel[i]) begin
            slot_valid[i] <= 1'b0;
          end else if (slot_valid[i]) begin
            slot_age[i] <= slot_age[i] + AW'(1);
          end
        end
      end
    end
  end

  // Tags carry no reset: only valid slots are ever compared.
  always_ff @(posedge clk) begin
    if (en && upd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_sel[i]) begin
          slot_page[i] <= id;
        end
      end
    end
  end

endmodule

// ===== verif/lru_page_tag_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_tag_store_tb: self-checking bench for the LRU page tag store
// A directed opening covers the empty store, hits, misses, evicts and a
// victim on a full store. Random phases follow, each under its own capacity
// (out-of-range values included). Every response is checked field by field
// against an in-bench LRU predictor, with bursty requests and a stalling
// receiver.
// ----------------------------------------------------------------------------
module lru_page_tag_store_tb;
  import lpts_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_wen   = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = CAP_RESET;

  lru_page_tag_store #(
    .ENTRIES (ENTRIES),
    .ID_WIDTH(PAGE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be offered, and responses predicted but not yet seen.
  req_t request_q[$];
  rsp_t outcome_q[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Predictor state: a private copy of the tag array and the capacity.
  bit               tag_live[ENTRIES];
  logic [PAGE_W-1:0] tag_page[ENTRIES];
  int unsigned      tag_age[ENTRIES];
  int unsigned      resident;
  logic [CFG_W-1:0] capacity_reg;

  // Remove slot s; entries older than it each move one step more recent.
  function automatic void retire_slot(int s);
    int i;
    tag_live[s] = 1'b0;
    for (i = 0; i < ENTRIES; i++)
      if (tag_live[i] && tag_age[i] > tag_age[s]) tag_age[i]--;
    if (resident > 0) resident--;
  endfunction

  // Apply one request to the predictor and return the response it should give.
  function automatic rsp_t lru_lookup(req_t r);
    rsp_t        o;
    kind_t       k;
    int          s, lru, fs, i;
    int unsigned limit;
    o = '0;
    k = kind_t'(r.kind);
    s = -1;
    for (i = 0; i < ENTRIES; i++)
      if (s < 0 && tag_live[i] && tag_page[i] == r.page_id) s = i;
    // Zero acts as one, anything past the array size as the array size.
    limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
    o.hit = (s >= 0);
    case (k)
      KIND_LOAD, KIND_SAVE: begin
        o.write_back = (k == KIND_SAVE);
        if (s >= 0) begin
          // Hit: promote to most recent, younger entries age by one.
          for (i = 0; i < ENTRIES; i++)
            if (tag_live[i] && tag_age[i] < tag_age[s]) tag_age[i]++;
          tag_age[s] = 0;
        end else begin
          o.fetch_needed = (k == KIND_LOAD);
          // Full (or over a lowered capacity): drop only the single oldest.
          if (resident >= limit) begin
            lru = -1;
            for (i = 0; i < ENTRIES; i++)
              if (tag_live[i] && (lru < 0 || tag_age[i] > tag_age[lru])) lru = i;
            if (lru >= 0) begin
              o.victim_valid = 1'b1;
              o.victim_id    = tag_page[lru];
              retire_slot(lru);
            end
          end
          fs = -1;
          for (i = 0; i < ENTRIES; i++)
            if (fs < 0 && !tag_live[i]) fs = i;
          if (fs >= 0) begin
            for (i = 0; i < ENTRIES; i++)
              if (tag_live[i]) tag_age[i]++;
            tag_live[fs] = 1'b1;
            tag_page[fs] = r.page_id;
            tag_age[fs]  = 0;
            resident++;
          end
        end
      end
      KIND_EVICT: begin
        if (s >= 0) retire_slot(s);
      end
      default: begin
      end
    endcase
    o.occupancy = resident[OCC_W-1:0];
    return o;
  endfunction

  function automatic void note_field(string name, logic [PAGE_W-1:0] want,
                                     logic [PAGE_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued requests in bursts of random length, with random
  // gaps between bursts. Hold valid and payload until the transfer happens.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        req       <= request_q.pop_front();
        req_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // A quarter of bursts run straight into the next one.
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the response transfer first, then predict for the request
  // transfer of the same edge, so the queue order never depends on the
  // scheduler. The receiver stalls on a pattern of its own: runs of always
  // ready, half ready and mostly stalled.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_run  = 0;

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: response with nothing expected, got %p", $time, rsp);
        end else begin
          want = outcome_q.pop_front();
          note_field("hit",          PAGE_W'(want.hit),          PAGE_W'(rsp.hit));
          note_field("fetch_needed", PAGE_W'(want.fetch_needed), PAGE_W'(rsp.fetch_needed));
          note_field("write_back",   PAGE_W'(want.write_back),   PAGE_W'(rsp.write_back));
          note_field("victim_valid", PAGE_W'(want.victim_valid), PAGE_W'(rsp.victim_valid));
          note_field("victim_id",    want.victim_id,             rsp.victim_id);
          note_field("occupancy",    PAGE_W'(want.occupancy),    PAGE_W'(rsp.occupancy));
        end
      end
      if (req_valid && req_ready) outcome_q.push_back(lru_lookup(req));

      if (stall_run == 0) begin
        stall_run  = $urandom_range(20, 200);
        stall_mode = $urandom_range(0, 2);
      end
      stall_run--;
      case (stall_mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= ($urandom_range(0, 1) == 1);
        default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: end the run if nothing transfers on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lru_page_tag_store: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void push_req(kind_t k, logic [PAGE_W-1:0] id);
    req_t r;
    r.kind    = k;
    r.page_id = id;
    request_q.push_back(r);
  endfunction

  // Wait until every request has transferred and every response has come
  // back, then let the pipeline settle.
  task automatic wait_idle();
    while (request_q.size() != 0 || req_valid || outcome_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wen      <= 1'b1;
    cfg_wdata    <= value;
    capacity_reg = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Random phase over a pool of ids sized a little above the capacity, so
  // hits, misses and victims all turn up. Ids take every bit both ways.
  task automatic queue_random_phase(int n);
    logic [PAGE_W-1:0] pool[$];
    int                limit, pool_n, j, w;
    logic [PAGE_W-1:0] id;
    kind_t             k;
    limit  = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
    pool_n = limit + $urandom_range(1, limit + 2);
    for (j = 0; j < pool_n; j++) begin
      case ($urandom_range(0, 3))
        0:       pool.push_back($urandom_range(0, 15));
        1:       pool.push_back(32'hFFFF_FFFF - $urandom_range(0, 15));
        default: pool.push_back($urandom);
      endcase
    end
    for (j = 0; j < n; j++) begin
      w = $urandom_range(0, 99);
      if (w < 35)      k = KIND_LOAD;
      else if (w < 60) k = KIND_SAVE;
      else if (w < 80) k = KIND_EVICT;
      else             k = KIND_QUERY;
      // Mostly pool ids; the odd stray id forces a cold miss.
      id = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
      push_req(k, id);
    end
  endtask

  initial begin
    int i;
    logic [CFG_W-1:0] cap_plan[$];

    // Predictor reset: empty store, capacity at its reset value.
    for (i = 0; i < ENTRIES; i++) begin
      tag_live[i] = 1'b0;
      tag_page[i] = '0;
      tag_age[i]  = 0;
    end
    resident     = 0;
    capacity_reg = CAP_RESET;

    // Directed opening at the reset capacity.
    push_req(KIND_QUERY, 32'h0000_0000);   // query on an empty store
    push_req(KIND_EVICT, 32'h1234_5678);   // evict of an absent id
    push_req(KIND_LOAD,  32'h0000_0000);   // load miss: fetch
    push_req(KIND_SAVE,  32'hFFFF_FFFF);   // save miss: write back, no fetch
    push_req(KIND_LOAD,  32'h0000_0000);   // load hit
    push_req(KIND_SAVE,  32'h0000_0000);   // save hit still writes back
    push_req(KIND_QUERY, 32'hFFFF_FFFF);   // query hit
    push_req(KIND_EVICT, 32'hFFFF_FFFF);   // evict hit
    push_req(KIND_EVICT, 32'hFFFF_FFFF);   // second evict finds nothing
    for (i = 1; i < ENTRIES; i++)
      push_req(KIND_LOAD, 32'h8000_0000 | i);  // fill the store
    push_req(KIND_SAVE, 32'h7FFF_FFFF);    // full store: oldest id is the victim

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Capacities: first lowered well below the occupancy left by the fill,
    // then both extremes, zero and values past the array size.
    cap_plan = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16, 5'd5, 5'd17, 5'd12};
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      queue_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lru_page_tag_store: match");
    end else begin
      $display("lru_page_tag_store: mismatch");
    end
    $finish;
  end

endmodule
